>>> rtl/trms_pkg.sv
// ============================================================================
// trms_pkg: shared types and constants for the three-axis RMS block
// Holds the transaction structs and the fixed field widths.
// ============================================================================
package trms_pkg;

   localparam int unsigned OutBits = 16;
   localparam int unsigned LenBits = 11;
   localparam int unsigned RmsLenReset = 160;

   typedef struct packed {
      logic signed [15:0] sample_x;
      logic signed [15:0] sample_y;
      logic signed [15:0] sample_z;
   } req_type;

   typedef struct packed {
      logic signed [15:0] avg_x;
      logic signed [15:0] avg_y;
      logic signed [15:0] avg_z;
      logic               rms_done;
      logic        [15:0] rms_x;
      logic        [15:0] rms_y;
      logic        [15:0] rms_z;
      logic        [15:0] peak_rms_x;
      logic        [15:0] peak_rms_y;
      logic        [15:0] peak_rms_z;
   } rsp_type;

   // Command from the sequencer to the per-axis lanes.
   typedef struct packed {
      logic start;
      logic close;
   } lane_cmd_type;

endpackage

>>> rtl/triaxis_rms_and_moving_average.sv
// Processing: each accepted transaction runs a divide of 29 steps in every
// lane; a period close adds a divide of 42 steps and a root of 21 steps.
// A new transaction is taken only after the last result has been accepted;
// the bit-serial divider and square root of the three axis lanes set the pace.
// Reset: synchronous, active high; clears sums, counts, RMS and peak values
// and sets the window length to 160. The sample ring needs no clearing.
// ============================================================================
// triaxis_rms_and_moving_average: three-axis moving average and block RMS
// Three axis lanes run side by side; the top level merges their results,
// holds the ring memory and the peak values, and owns the handshakes.
// ============================================================================
module triaxis_rms_and_moving_average #(
   parameter int unsigned AVG_DEPTH   = 4096,
   parameter int unsigned SAMPLE_BITS = 16,
   parameter int unsigned RMS_LEN_MAX = 1024
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  trms_pkg::req_type         req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output trms_pkg::rsp_type         rsp_data,
   input  logic                      csr_we,
   input  logic [trms_pkg::LenBits-1:0] csr_wdata
);

   // Derived widths. The ring index needs log2 of the depth; the fill count
   // must hold the depth itself.
   localparam int unsigned IdxBits = $clog2(AVG_DEPTH);
   localparam int unsigned CntBits = $clog2(AVG_DEPTH + 1);
   localparam int unsigned PerBits = $clog2(RMS_LEN_MAX + 1);
   localparam int unsigned SumBits = SAMPLE_BITS + CntBits;
   localparam int unsigned SqBits  = 2 * SAMPLE_BITS + PerBits - 1;

   typedef enum logic [1:0] {IDLE, READ, WORK, SEND} state_type;

   state_type state_ff;
   logic [trms_pkg::LenBits-1:0] len_ff;
   logic [IdxBits-1:0] widx_ff;
   logic full_ff;
   logic [PerBits-1:0] per_ff;
   logic [15:0] peak_ff [3];
   logic signed [SAMPLE_BITS-1:0] smp_ff [3];
   logic signed [SAMPLE_BITS-1:0] old_ff [3];
   logic [3*SAMPLE_BITS-1:0] ring_mem [AVG_DEPTH];
   logic [3*SAMPLE_BITS-1:0] ring_rd_ff;
   logic close_ff, started_ff;
   trms_pkg::rsp_type rsp_ff;

   trms_pkg::lane_cmd_type cmd;
   logic [CntBits-1:0] count;
   logic [PerBits-1:0] per_next, eff_len;
   logic close_now;
   logic [2:0] busy;
   logic [15:0] avg [3];
   logic [15:0] rms [3];

   // Effective window: zero acts as one, large values saturate.
   always_comb begin
      if (len_ff == '0) begin
         eff_len = PerBits'(1);
      end else if (32'(len_ff) > RMS_LEN_MAX) begin
         eff_len = PerBits'(RMS_LEN_MAX);
      end else begin
         eff_len = PerBits'(len_ff);
      end
      per_next = per_ff + PerBits'(1);
      // The close flag must reach the lanes with the start strobe, so it is
      // computed combinationally from the period count in READ.
      close_now = (per_next >= eff_len);
      // Fill count after this sample is written.
      if (full_ff || (32'(widx_ff) == AVG_DEPTH - 1)) begin
         count = CntBits'(AVG_DEPTH);
      end else begin
         count = CntBits'(widx_ff) + CntBits'(1);
      end
      cmd.start = (state_ff == READ);
      cmd.close = close_now;
   end

   for (genvar a = 0; a < 3; a++) begin : g_lane
      trms_lane #(
         .SAMPLE_BITS(SAMPLE_BITS),
         .SUM_BITS(SumBits),
         .SQ_BITS(SqBits),
         .CNT_BITS(CntBits),
         .PER_BITS(PerBits)
      ) u_lane (
         .clock(clock),
         .reset(reset),
         .cmd(cmd),
         .sample(smp_ff[a]),
         .oldest(signed'(ring_rd_ff[a*SAMPLE_BITS +: SAMPLE_BITS])),
         .sub_old(full_ff),
         .count(count),
         .period(per_next),
         .busy(busy[a]),
         .avg(avg[a]),
         .rms(rms[a])
      );
   end

   // The ring holds x in the low bits, then y, then z.
   always_ff @(posedge clock) begin
      if (state_ff == READ) begin
         ring_mem[widx_ff] <= {smp_ff[2], smp_ff[1], smp_ff[0]};
      end
      ring_rd_ff <= ring_mem[widx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= IDLE;
         len_ff     <= trms_pkg::LenBits'(trms_pkg::RmsLenReset);
         widx_ff    <= '0;
         full_ff    <= 1'b0;
         per_ff     <= '0;
         close_ff   <= 1'b0;
         started_ff <= 1'b0;
         for (int a = 0; a < 3; a++) peak_ff[a] <= '0;
      end else begin
         if (csr_we) len_ff <= csr_wdata;
         case (state_ff)
            IDLE: begin
               if (req_valid) begin
                  smp_ff[0] <= SAMPLE_BITS'(req_data.sample_x);
                  smp_ff[1] <= SAMPLE_BITS'(req_data.sample_y);
                  smp_ff[2] <= SAMPLE_BITS'(req_data.sample_z);
                  state_ff  <= READ;
               end
            end
            READ: begin
               // The ring read of the oldest entry has landed; lanes start.
               // The period is decided here, together with the lane start.
               close_ff   <= close_now;
               per_ff     <= close_now ? '0 : per_next;
               started_ff <= 1'b1;
               state_ff   <= WORK;
               if (32'(widx_ff) == AVG_DEPTH - 1) begin
                  widx_ff <= '0;
                  full_ff <= 1'b1;
               end else begin
                  widx_ff <= widx_ff + IdxBits'(1);
               end
            end
            WORK: begin
               started_ff <= 1'b0;
               if (!started_ff && busy == 3'b000) begin
                  rsp_ff.avg_x <= avg[0];
                  rsp_ff.avg_y <= avg[1];
                  rsp_ff.avg_z <= avg[2];
                  rsp_ff.rms_done <= close_ff;
                  rsp_ff.rms_x <= rms[0];
                  rsp_ff.rms_y <= rms[1];
                  rsp_ff.rms_z <= rms[2];
                  for (int a = 0; a < 3; a++) begin
                     if (close_ff && rms[a] > peak_ff[a]) peak_ff[a] <= rms[a];
                  end
                  rsp_ff.peak_rms_x <= (close_ff && rms[0] > peak_ff[0]) ? rms[0] : peak_ff[0];
                  rsp_ff.peak_rms_y <= (close_ff && rms[1] > peak_ff[1]) ? rms[1] : peak_ff[1];
                  rsp_ff.peak_rms_z <= (close_ff && rms[2] > peak_ff[2]) ? rms[2] : peak_ff[2];
                  state_ff <= SEND;
               end
            end
            SEND: begin
               if (rsp_ready) state_ff <= IDLE;
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

   assign req_ready = (state_ff == IDLE);
   assign rsp_valid = (state_ff == SEND);
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_one_owner: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("input and output open together");
   a_lanes_start: assert property (@(posedge clock) disable iff (reset)
      (state_ff == READ) |=> (busy == 3'b111)) else $error("lane did not start");
   a_period_bound: assert property (@(posedge clock) disable iff (reset)
      (32'(per_ff) < RMS_LEN_MAX)) else $error("period overrun");
`endif

endmodule

>>> rtl/trms_lane.sv
// ============================================================================
// trms_lane: one axis of the moving average and RMS computation
// Keeps the axis sums and runs bit-serial divides and a square root.
// ============================================================================
module trms_lane #(
   parameter int unsigned SAMPLE_BITS = 16,
   parameter int unsigned SUM_BITS    = 29,
   parameter int unsigned SQ_BITS     = 42,
   parameter int unsigned CNT_BITS    = 13,
   parameter int unsigned PER_BITS    = 11
) (
   input  logic                          clock,
   input  logic                          reset,
   input  trms_pkg::lane_cmd_type        cmd,
   input  logic signed [SAMPLE_BITS-1:0] sample,
   input  logic signed [SAMPLE_BITS-1:0] oldest,
   input  logic                          sub_old,
   input  logic [CNT_BITS-1:0]           count,
   input  logic [PER_BITS-1:0]           period,
   output logic                          busy,
   output logic [15:0]                   avg,
   output logic [15:0]                   rms
);

   localparam int unsigned RootBits = (SQ_BITS + 1) / 2;
   localparam int unsigned PhBits   = 2;

   typedef enum logic [1:0] {IDLE, DIVA, DIVQ, ROOT} state_type;

   state_type state_ff;
   logic [PhBits-1:0] unused_ff;
   logic signed [SUM_BITS-1:0] sum_ff;
   logic [SQ_BITS-1:0] sq_ff;
   logic [SUM_BITS-1:0] rem_ff, quo_ff;
   logic [SQ_BITS-1:0] qrem_ff, qquo_ff;
   logic [SQ_BITS-1:0] rn_ff;
   logic [RootBits-1:0] root_ff;
   logic [RootBits:0] rr_ff;
   logic [6:0] step_ff;
   logic neg_ff, close_ff;
   logic [15:0] avg_ff, rms_ff;
   // Divisors captured with the start strobe; the top level moves on.
   logic [CNT_BITS-1:0] cnt_ff;
   logic [PER_BITS-1:0] prd_ff;

   logic signed [SUM_BITS-1:0] sum_in;
   logic [SQ_BITS-1:0] sq_in;
   logic [SUM_BITS-1:0] mag;
   logic [SUM_BITS:0] rem_sh;
   logic [SQ_BITS:0] qrem_sh;
   logic [RootBits+1:0] rr_sh, trial;

   always_comb begin
      sum_in = sum_ff + SUM_BITS'(sample)
               - (sub_old ? SUM_BITS'(oldest) : SUM_BITS'(0));
      sq_in  = sq_ff + SQ_BITS'(unsigned'(SQ_BITS'(sample) * SQ_BITS'(sample)));
      mag    = sum_in[SUM_BITS-1] ? SUM_BITS'(-sum_in) : SUM_BITS'(sum_in);
      rem_sh = {rem_ff, quo_ff[SUM_BITS-1]};
      qrem_sh = {qrem_ff, qquo_ff[SQ_BITS-1]};
      rr_sh  = {rr_ff[RootBits-1:0], rn_ff[SQ_BITS-1 -: 2]};
      trial  = {root_ff, 2'b01};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         sum_ff   <= '0;
         sq_ff    <= '0;
         rms_ff   <= '0;
         unused_ff <= '0;
      end else begin
         unused_ff <= '0;
         case (state_ff)
            IDLE: begin
               if (cmd.start) begin
                  sum_ff   <= sum_in;
                  sq_ff    <= sq_in;
                  neg_ff   <= sum_in[SUM_BITS-1];
                  quo_ff   <= mag;
                  rem_ff   <= '0;
                  close_ff <= cmd.close;
                  qquo_ff  <= sq_in;
                  qrem_ff  <= '0;
                  step_ff  <= '0;
                  cnt_ff   <= count;
                  prd_ff   <= period;
                  state_ff <= DIVA;
               end
            end
            DIVA: begin
               if (rem_sh >= (SUM_BITS+1)'(cnt_ff)) begin
                  rem_ff <= SUM_BITS'(rem_sh - (SUM_BITS+1)'(cnt_ff));
                  quo_ff <= {quo_ff[SUM_BITS-2:0], 1'b1};
               end else begin
                  rem_ff <= SUM_BITS'(rem_sh);
                  quo_ff <= {quo_ff[SUM_BITS-2:0], 1'b0};
               end
               if (step_ff == 7'(SUM_BITS - 1)) begin
                  step_ff <= '0;
                  avg_ff  <= 16'(neg_ff ? -(SUM_BITS'(rem_sh >= (SUM_BITS+1)'(cnt_ff))
                             | {quo_ff[SUM_BITS-2:0], 1'b0})
                             : ({quo_ff[SUM_BITS-2:0], 1'b0}
                             | SUM_BITS'(rem_sh >= (SUM_BITS+1)'(cnt_ff))));
                  state_ff <= close_ff ? DIVQ : IDLE;
               end else begin
                  step_ff <= step_ff + 7'd1;
               end
            end
            DIVQ: begin
               if (qrem_sh >= (SQ_BITS+1)'(prd_ff)) begin
                  qrem_ff <= SQ_BITS'(qrem_sh - (SQ_BITS+1)'(prd_ff));
                  qquo_ff <= {qquo_ff[SQ_BITS-2:0], 1'b1};
               end else begin
                  qrem_ff <= SQ_BITS'(qrem_sh);
                  qquo_ff <= {qquo_ff[SQ_BITS-2:0], 1'b0};
               end
               if (step_ff == 7'(SQ_BITS - 1)) begin
                  step_ff <= '0;
                  rn_ff   <= {qquo_ff[SQ_BITS-2:0],
                              qrem_sh >= (SQ_BITS+1)'(prd_ff)};
                  root_ff <= '0;
                  rr_ff   <= '0;
                  sq_ff   <= '0;
                  state_ff <= ROOT;
               end else begin
                  step_ff <= step_ff + 7'd1;
               end
            end
            ROOT: begin
               // Restoring square root, two radicand bits per step.
               rn_ff <= {rn_ff[SQ_BITS-3:0], 2'b00};
               if (rr_sh >= trial) begin
                  rr_ff   <= (RootBits+1)'(rr_sh - trial);
                  root_ff <= {root_ff[RootBits-2:0], 1'b1};
               end else begin
                  rr_ff   <= (RootBits+1)'(rr_sh);
                  root_ff <= {root_ff[RootBits-2:0], 1'b0};
               end
               if (step_ff == 7'(RootBits - 1)) begin
                  rms_ff   <= 16'({root_ff[RootBits-2:0], rr_sh >= trial});
                  state_ff <= IDLE;
               end else begin
                  step_ff <= step_ff + 7'd1;
               end
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

   assign busy = (state_ff != IDLE) || (unused_ff != '0);
   assign avg  = avg_ff;
   assign rms  = rms_ff;

endmodule
